// ===== hdl/qspd_pkg.sv =====
// shared types and constants for the query string percent decoder
// no dependencies

package qspd_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PCT,
        ESC_DIGIT
    } t_esc_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_qspd_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       in_value_part;
        logic       pair_end;
        logic       run_last;
    } t_qspd_out;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       in_value_part;
    } t_qspd_res;

    typedef struct packed {
        t_qspd_res [MAX_RES-1:0] res;
        logic [RES_CNT_W-1:0]    cnt;
        logic                    pair_end;
    } t_qspd_run;

endpackage

// ===== hdl/qspd_front.sv =====
// front part: classifies each input byte and builds its run of up to three results
// depends on qspd_pkg

module qspd_front import qspd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_qspd_in  i_in,
    output logic      o_push,
    output t_qspd_run o_run
);

    t_esc_phase r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_side, n_side;

    t_qspd_run  w_run;
    logic       w_ending;
    logic [4:0] w_hex_hi;
    logic [4:0] w_hex_lo;

    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h57)};
        end
        return 5'b0;
    endfunction

    function automatic t_qspd_run put(input t_qspd_run r, input logic [7:0] b,
                                      input logic v, input logic s);
        t_qspd_run q;
        q = r;
        if (q.cnt != RES_CNT_W'(MAX_RES)) begin
            q.res[q.cnt].out_byte      = v ? b : 8'h00;
            q.res[q.cnt].byte_valid    = v;
            q.res[q.cnt].in_value_part = s;
            q.cnt                      = q.cnt + 1'b1;
        end
        return q;
    endfunction

    function automatic t_qspd_run flush(input t_qspd_run r, input t_esc_phase ph,
                                        input logic [7:0] held, input logic s);
        t_qspd_run q;
        q = r;
        if (ph != ESC_IDLE) begin
            q = put(q, CH_PCT, 1'b1, s);
        end
        if (ph == ESC_DIGIT) begin
            q = put(q, held, 1'b1, s);
        end
        return q;
    endfunction

    always_comb begin
        w_run    = '0;
        w_ending = 1'b0;
        n_phase  = r_phase;
        n_held   = r_held;
        n_side   = r_side;
        w_hex_hi = hex_nib(r_held);
        w_hex_lo = hex_nib(i_in.in_byte);

        if (i_in.in_byte == CH_AMP) begin
            w_run    = flush(w_run, n_phase, n_held, n_side);
            n_phase  = ESC_IDLE;
            w_ending = 1'b1;
        end else if (i_in.in_byte == CH_EQ && !n_side) begin
            w_run   = flush(w_run, n_phase, n_held, n_side);
            n_phase = ESC_IDLE;
            n_side  = 1'b1;
        end else begin
            case (r_phase)
                ESC_IDLE: begin
                    if (i_in.in_byte == CH_PCT) begin
                        n_phase = ESC_PCT;
                    end else if (i_in.in_byte == CH_PLUS) begin
                        w_run = put(w_run, CH_SPACE, 1'b1, n_side);
                    end else begin
                        w_run = put(w_run, i_in.in_byte, 1'b1, n_side);
                    end
                end
                ESC_PCT: begin
                    n_held  = i_in.in_byte;
                    n_phase = ESC_DIGIT;
                end
                ESC_DIGIT: begin
                    if (w_hex_hi[4] && w_hex_lo[4]) begin
                        w_run = put(w_run, {w_hex_hi[3:0], w_hex_lo[3:0]}, 1'b1, n_side);
                    end else begin
                        w_run = put(w_run, CH_PCT, 1'b1, n_side);
                        w_run = put(w_run, r_held, 1'b1, n_side);
                        w_run = put(w_run, i_in.in_byte, 1'b1, n_side);
                    end
                    n_phase = ESC_IDLE;
                end
                default: begin
                    n_phase = ESC_IDLE;
                end
            endcase
        end

        if (i_in.final_byte && !w_ending) begin
            w_run    = flush(w_run, n_phase, n_held, n_side);
            n_phase  = ESC_IDLE;
            w_ending = 1'b1;
        end

        if (w_ending) begin
            if (w_run.cnt == '0) begin
                w_run = put(w_run, 8'h00, 1'b0, n_side);
            end
            n_side  = 1'b0;
            n_phase = ESC_IDLE;
        end
        if (i_in.final_byte) begin
            n_held = 8'h00;
        end
        w_run.pair_end = w_ending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_held  <= 8'h00;
            r_side  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_side  <= n_side;
        end
    end

    assign o_push = i_accept && (w_run.cnt != '0);
    assign o_run  = w_run;

endmodule

// ===== hdl/qspd_queue.sv =====
// short queue of result runs between the front and back parts
// depends on qspd_pkg

module qspd_queue import qspd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_qspd_run i_data,
    input  logic      i_pop,
    output t_qspd_run o_data,
    output logic      o_full,
    output logic      o_empty
);

    t_qspd_run         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? QPTR_W'(r_wp + 1'b1) : r_wp;
        n_rp  = i_pop ? QPTR_W'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== hdl/qspd_back.sv =====
// back part: walks the head run into the output register one result per cycle
// while the register is free or being taken; depends on qspd_pkg

module qspd_back import qspd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qspd_run i_head,
    input  logic      i_empty,
    output logic      o_pop,
    input  logic      i_ready,
    output logic      o_valid,
    output t_qspd_out o_data
);

    logic [RES_CNT_W-1:0] r_idx, n_idx;
    logic                 r_ov, n_ov;
    t_qspd_out            r_out;

    t_qspd_res w_sel;
    logic      w_last;
    logic      w_load;

    always_comb begin
        case (r_idx)
            RES_CNT_W'(0): w_sel = i_head.res[0];
            RES_CNT_W'(1): w_sel = i_head.res[1];
            default:       w_sel = i_head.res[MAX_RES-1];
        endcase
        w_last = (r_idx == RES_CNT_W'(i_head.cnt - 1'b1));
        w_load = !i_empty && (!r_ov || i_ready);
        o_pop  = w_load && w_last;
        n_idx  = r_idx;
        n_ov   = r_ov;
        if (w_load) begin
            n_ov  = 1'b1;
            n_idx = w_last ? '0 : RES_CNT_W'(r_idx + 1'b1);
        end else if (i_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_byte      <= w_sel.out_byte;
            r_out.byte_valid    <= w_sel.byte_valid;
            r_out.in_value_part <= w_sel.in_value_part;
            r_out.pair_end      <= i_head.pair_end && w_last;
            r_out.run_last      <= w_last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// ===== hdl/query_string_percent_decoder_core.sv =====
// query string percent decoder, top level: front, run queue, back
// throughput: one input byte per cycle while the four-run queue has room
// a byte that yields several results, such as a three-result escape, sends them out one result at a time
// path: a byte's run is written into the queue, then each result is loaded into the back part's output register
// reset: synchronous active low, clears escape state, queue and output valid
// depends on qspd_pkg, qspd_front, qspd_queue, qspd_back

module query_string_percent_decoder_core import qspd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_qspd_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_qspd_out o_out_data
);

    logic      w_accept;
    logic      w_push;
    logic      w_pop;
    logic      w_full;
    logic      w_empty;
    t_qspd_run w_run;
    t_qspd_run w_head;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    qspd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in_data),
        .o_push   (w_push),
        .o_run    (w_run)
    );

    qspd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_run),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    qspd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("run pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("run popped from an empty queue");

    a_pair_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pair_end |-> o_out_data.run_last)
        else $error("pair end not on the last result of a run");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |->
            o_out_data.pair_end && (o_out_data.out_byte == 8'h00))
        else $error("result without a byte that does not close a pair");
`endif

endmodule
